### src/fap_pkg.sv
`default_nettype none

package fap_pkg;

    // Commands
    localparam logic [1:0] CMD_PUSH    = 2'd0;
    localparam logic [1:0] CMD_ACQUIRE = 2'd1;
    localparam logic [1:0] CMD_RELEASE = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_ACCEPTED    = 3'd0;
    localparam logic [2:0] ST_PRE_SESSION = 3'd1;
    localparam logic [2:0] ST_NO_SLOT     = 3'd2;
    localparam logic [2:0] ST_STRAGGLER   = 3'd3;
    localparam logic [2:0] ST_ACQ_EMPTY   = 3'd4;
    localparam logic [2:0] ST_VIEW        = 3'd5;
    localparam logic [2:0] ST_RELEASED    = 3'd6;

    // Set events
    localparam logic [1:0] EV_NONE       = 2'd0;
    localparam logic [1:0] EV_FULL       = 2'd1;
    localparam logic [1:0] EV_PARTIAL    = 2'd2;
    localparam logic [1:0] EV_UNDERFILL  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_CAMERA_COUNT = 2'd0;
    localparam logic [1:0] REG_START_TIME   = 2'd1;

    localparam logic [4:0] CAMERA_COUNT_RESET = 5'd4;
    localparam int         MIN_SET_FRAMES     = 2;
    localparam int         EFF_W              = 7;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  cam_id;
        logic [63:0] frame_time;
        logic [63:0] frame_ptr;
        logic [15:0] frame_pitch;
        logic [2:0]  release_slot;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [1:0]  set_event;
        logic        oldest_dropped;
        logic [2:0]  slot_number;
        logic [63:0] set_time;
        logic [4:0]  view_count;
        logic [7:0]  view_camera;
        logic [63:0] view_ptr;
        logic [15:0] view_pitch;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [4:0]  camera_count;
        logic [63:0] start_time;
    } cfg_t;

endpackage

`default_nettype wire

### src/fap_front.sv
`default_nettype none

module fap_front (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  fap_pkg::in_item_t   request,
    output logic                busy,
    output logic                q_valid,
    output fap_pkg::in_item_t   q_item,
    input  wire                 q_pop
);
    import fap_pkg::*;

    // Two-entry command queue
    in_item_t   slot_reg [2];
    logic       rd_ptr_reg;
    logic       wr_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push;

    assign busy    = (cnt_reg == 2'd2);
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_item  = slot_reg[rd_ptr_reg];

    // Store accepted items
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= request;
        end
    end

    // Advance pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !(q_pop && q_valid))
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (!push && q_pop && q_valid)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

### src/fap_back.sv
`default_nettype none

module fap_back #(
    parameter int SLOT_COUNT  = 8,
    parameter int MAX_CAMERAS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  fap_pkg::cfg_t       cfg,
    input  wire                 q_valid,
    input  fap_pkg::in_item_t   q_item,
    output logic                q_pop,
    output logic                result_valid,
    output fap_pkg::out_item_t  result
);
    import fap_pkg::*;

    localparam int SW    = $clog2(SLOT_COUNT);
    localparam int CNW   = $clog2(SLOT_COUNT + 1);
    localparam int FW    = $clog2(MAX_CAMERAS + 1);
    localparam int DEPTH = SLOT_COUNT * MAX_CAMERAS;
    localparam int AW    = $clog2(DEPTH);

    typedef enum logic [3:0] {
        S_IDLE, S_P0, S_P1, S_P2, S_P3, S_P4, S_A0, S_AV, S_R0
    } state_t;

    state_t          state_reg;
    in_item_t        cur_reg;
    out_item_t       result_reg;
    logic            result_valid_reg;

    logic [SW-1:0]   free_q_reg [SLOT_COUNT];
    logic [SW-1:0]   free_head_reg;
    logic [CNW-1:0]  free_cnt_reg;
    logic [SW-1:0]   done_q_reg [SLOT_COUNT];
    logic [SW-1:0]   done_head_reg;
    logic [CNW-1:0]  done_cnt_reg;
    logic            open_valid_reg;
    logic [SW-1:0]   open_slot_reg;
    logic [63:0]     slot_time_reg [SLOT_COUNT];
    logic [FW-1:0]   slot_fill_reg [SLOT_COUNT];

    logic [1:0]      ev1_reg;
    logic [1:0]      ev2_reg;
    logic            dropped_reg;
    logic            strag_reg;
    logic [SW-1:0]   acq_slot_reg;
    logic [FW-1:0]   acq_n_reg;
    logic [FW-1:0]   rd_idx_reg;
    logic [FW-1:0]   emit_idx_reg;

    // View store
    logic [7:0]      vcam_mem   [DEPTH];
    logic [63:0]     vptr_mem   [DEPTH];
    logic [15:0]     vpitch_mem [DEPTH];
    logic [7:0]      rd_cam_reg;
    logic [63:0]     rd_ptr_reg;
    logic [15:0]     rd_pitch_reg;

    function automatic logic [SW-1:0] wrap_idx(input logic [CNW:0] v);
        logic [CNW:0] lim;
        lim = (CNW + 1)'(SLOT_COUNT);
        if (v >= lim)
        begin
            return SW'(v - lim);
        end
        return SW'(v);
    endfunction

    function automatic logic [AW-1:0] view_addr(input logic [SW-1:0] s,
                                                input logic [FW-1:0] i);
        return AW'(AW'(s) * AW'(MAX_CAMERAS) + AW'(i));
    endfunction

    logic [EFF_W-1:0] eff_cams;
    logic [SW-1:0]    free_tail;
    logic [SW-1:0]    done_tail;
    logic [SW-1:0]    open_s;
    logic [FW-1:0]    open_fill;
    logic [63:0]      open_time;
    logic [63:0]      t;
    logic             close_en;
    logic [1:0]       close_ev;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic [AW-1:0]    rd_addr;
    logic [FW-1:0]    rd_idx_safe;
    logic [SW-1:0]    rel_s;
    logic             rel_ok;

    assign t         = cur_reg.frame_time;
    assign open_s    = open_slot_reg;
    assign open_fill = slot_fill_reg[open_s];
    assign open_time = slot_time_reg[open_s];
    assign free_tail = wrap_idx((CNW + 1)'(free_head_reg) + (CNW + 1)'(free_cnt_reg));
    assign done_tail = wrap_idx((CNW + 1)'(done_head_reg) + (CNW + 1)'(done_cnt_reg));
    assign rel_s     = SW'(cur_reg.release_slot);
    assign rel_ok    = (32'(cur_reg.release_slot) < SLOT_COUNT);

    // Effective camera count
    always_comb
    begin
        if (cfg.camera_count == 5'd0 || 32'(cfg.camera_count) > MAX_CAMERAS)
        begin
            eff_cams = EFF_W'(MAX_CAMERAS);
        end
        else
        begin
            eff_cams = EFF_W'(cfg.camera_count);
        end
    end

    // Close the open set: by newer timestamp at P0, by fill at P3
    always_comb
    begin
        close_en = 1'b0;
        if (state_reg == S_P0)
        begin
            close_en = (t >= cfg.start_time) && open_valid_reg && (t > open_time);
        end
        else if (state_reg == S_P3)
        begin
            close_en = !strag_reg && open_valid_reg && (EFF_W'(open_fill) >= eff_cams);
        end
        if (32'(open_fill) >= MIN_SET_FRAMES)
        begin
            close_ev = (EFF_W'(open_fill) >= eff_cams) ? EV_FULL : EV_PARTIAL;
        end
        else
        begin
            close_ev = EV_UNDERFILL;
        end
    end

    // View store addressing
    assign mem_we      = (state_reg == S_P2) && !(t < open_time)
                         && (32'(open_fill) < MAX_CAMERAS);
    assign wr_addr     = view_addr(open_s, open_fill);
    assign rd_idx_safe = (32'(rd_idx_reg) < MAX_CAMERAS) ? rd_idx_reg : '0;
    assign rd_addr     = (state_reg == S_A0) ? view_addr(done_q_reg[done_head_reg], '0)
                                             : view_addr(acq_slot_reg, rd_idx_safe);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            vcam_mem[wr_addr]   <= cur_reg.cam_id;
            vptr_mem[wr_addr]   <= cur_reg.frame_ptr;
            vpitch_mem[wr_addr] <= cur_reg.frame_pitch;
        end
        rd_cam_reg   <= vcam_mem[rd_addr];
        rd_ptr_reg   <= vptr_mem[rd_addr];
        rd_pitch_reg <= vpitch_mem[rd_addr];
    end

    assign q_pop        = (state_reg == S_IDLE) && q_valid;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Hold the current item; completed-set queue entries carry no reset
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_item;
        end
        if (close_en && 32'(open_fill) >= MIN_SET_FRAMES
            && 32'(done_cnt_reg) < SLOT_COUNT)
        begin
            done_q_reg[done_tail] <= open_s;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
            for (int i = 0; i < SLOT_COUNT; i++)
            begin
                free_q_reg[i]    <= SW'(i);
                slot_time_reg[i] <= '0;
                slot_fill_reg[i] <= '0;
            end
            free_head_reg  <= '0;
            free_cnt_reg   <= CNW'(SLOT_COUNT);
            done_head_reg  <= '0;
            done_cnt_reg   <= '0;
            open_valid_reg <= 1'b0;
            open_slot_reg  <= '0;
            ev1_reg        <= EV_NONE;
            ev2_reg        <= EV_NONE;
            dropped_reg    <= 1'b0;
            strag_reg      <= 1'b0;
            acq_slot_reg   <= '0;
            acq_n_reg      <= '0;
            rd_idx_reg     <= '0;
            emit_idx_reg   <= '0;
        end
        else
        begin
            result_valid_reg <= 1'b0;
            result_reg       <= '0;

            // Close the open set
            if (close_en)
            begin
                open_valid_reg <= 1'b0;
                if (32'(open_fill) >= MIN_SET_FRAMES)
                begin
                    if (32'(done_cnt_reg) < SLOT_COUNT)
                    begin
                        done_cnt_reg <= done_cnt_reg + CNW'(1);
                    end
                end
                else
                begin
                    slot_time_reg[open_s] <= '0;
                    slot_fill_reg[open_s] <= '0;
                    if (32'(free_cnt_reg) < SLOT_COUNT)
                    begin
                        free_q_reg[free_tail] <= open_s;
                        free_cnt_reg          <= free_cnt_reg + CNW'(1);
                    end
                end
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        case (q_item.cmd)
                            CMD_PUSH:    state_reg <= S_P0;
                            CMD_ACQUIRE: state_reg <= S_A0;
                            CMD_RELEASE: state_reg <= S_R0;
                            default:     state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_P0:
                begin
                    dropped_reg <= 1'b0;
                    if (t < cfg.start_time)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_reg.status <= ST_PRE_SESSION;
                        result_reg.last   <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        ev1_reg   <= close_en ? close_ev : EV_NONE;
                        state_reg <= S_P1;
                    end
                end

                // Claim a slot when no set is open
                S_P1:
                begin
                    state_reg <= S_P2;
                    if (!open_valid_reg)
                    begin
                        if (free_cnt_reg != '0)
                        begin
                            open_slot_reg <= free_q_reg[free_head_reg];
                            open_valid_reg <= 1'b1;
                            slot_time_reg[free_q_reg[free_head_reg]] <= t;
                            free_head_reg <= wrap_idx((CNW + 1)'(free_head_reg) + 1'b1);
                            free_cnt_reg  <= free_cnt_reg - CNW'(1);
                        end
                        else if (done_cnt_reg != '0)
                        begin
                            open_slot_reg <= done_q_reg[done_head_reg];
                            open_valid_reg <= 1'b1;
                            slot_time_reg[done_q_reg[done_head_reg]] <= t;
                            slot_fill_reg[done_q_reg[done_head_reg]] <= '0;
                            done_head_reg <= wrap_idx((CNW + 1)'(done_head_reg) + 1'b1);
                            done_cnt_reg  <= done_cnt_reg - CNW'(1);
                            dropped_reg   <= 1'b1;
                        end
                        else
                        begin
                            result_valid_reg     <= 1'b1;
                            result_reg.status    <= ST_NO_SLOT;
                            result_reg.set_event <= ev1_reg;
                            result_reg.last      <= 1'b1;
                            state_reg            <= S_IDLE;
                        end
                    end
                end

                // Add the frame to the open set unless it is older than the set or the set holds MAX_CAMERAS views
                S_P2:
                begin
                    strag_reg <= (t < open_time);
                    if (mem_we)
                    begin
                        slot_fill_reg[open_s] <= open_fill + FW'(1);
                    end
                    state_reg <= S_P3;
                end

                S_P3:
                begin
                    result_valid_reg <= 1'b1;
                    if (ev1_reg != EV_NONE && close_en)
                    begin
                        result_reg.status    <= ST_ACCEPTED;
                        result_reg.set_event <= ev1_reg;
                        ev2_reg              <= close_ev;
                        state_reg            <= S_P4;
                    end
                    else
                    begin
                        result_reg.status         <= strag_reg ? ST_STRAGGLER : ST_ACCEPTED;
                        result_reg.set_event      <= close_en ? close_ev : ev1_reg;
                        result_reg.oldest_dropped <= dropped_reg;
                        result_reg.last           <= 1'b1;
                        state_reg                 <= S_IDLE;
                    end
                end

                S_P4:
                begin
                    result_valid_reg          <= 1'b1;
                    result_reg.status         <= ST_ACCEPTED;
                    result_reg.set_event      <= ev2_reg;
                    result_reg.oldest_dropped <= dropped_reg;
                    result_reg.last           <= 1'b1;
                    state_reg                 <= S_IDLE;
                end

                // Take the oldest completed set
                S_A0:
                begin
                    if (done_cnt_reg == '0)
                    begin
                        result_valid_reg  <= 1'b1;
                        result_reg.status <= ST_ACQ_EMPTY;
                        result_reg.last   <= 1'b1;
                        state_reg         <= S_IDLE;
                    end
                    else
                    begin
                        done_head_reg <= wrap_idx((CNW + 1)'(done_head_reg) + 1'b1);
                        done_cnt_reg  <= done_cnt_reg - CNW'(1);
                        acq_slot_reg  <= done_q_reg[done_head_reg];
                        acq_n_reg     <= slot_fill_reg[done_q_reg[done_head_reg]];
                        rd_idx_reg    <= FW'(1);
                        emit_idx_reg  <= '0;
                        if (slot_fill_reg[done_q_reg[done_head_reg]] == '0)
                        begin
                            result_valid_reg       <= 1'b1;
                            result_reg.status      <= ST_VIEW;
                            result_reg.slot_number <= 3'(done_q_reg[done_head_reg]);
                            result_reg.set_time    <= slot_time_reg[done_q_reg[done_head_reg]];
                            result_reg.last        <= 1'b1;
                            state_reg              <= S_IDLE;
                        end
                        else
                        begin
                            state_reg <= S_AV;
                        end
                    end
                end

                // Stream one view a cycle
                S_AV:
                begin
                    result_valid_reg       <= 1'b1;
                    result_reg.status      <= ST_VIEW;
                    result_reg.slot_number <= 3'(acq_slot_reg);
                    result_reg.set_time    <= slot_time_reg[acq_slot_reg];
                    result_reg.view_count  <= 5'(acq_n_reg);
                    result_reg.view_camera <= rd_cam_reg;
                    result_reg.view_ptr    <= rd_ptr_reg;
                    result_reg.view_pitch  <= rd_pitch_reg;
                    rd_idx_reg             <= rd_idx_reg + FW'(1);
                    emit_idx_reg           <= emit_idx_reg + FW'(1);
                    if (emit_idx_reg + FW'(1) == acq_n_reg)
                    begin
                        result_reg.last <= 1'b1;
                        state_reg       <= S_IDLE;
                    end
                end

                S_R0:
                begin
                    if (rel_ok)
                    begin
                        slot_time_reg[rel_s] <= '0;
                        slot_fill_reg[rel_s] <= '0;
                        if (32'(free_cnt_reg) < SLOT_COUNT)
                        begin
                            free_q_reg[free_tail] <= rel_s;
                            free_cnt_reg          <= free_cnt_reg + CNW'(1);
                        end
                    end
                    result_valid_reg  <= 1'b1;
                    result_reg.status <= ST_RELEASED;
                    result_reg.last   <= 1'b1;
                    state_reg         <= S_IDLE;
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

### src/frameset_assembly_pool.sv
// Frame set assembly pool. Commands (push, acquire, release) enter a two-entry
// queue, taken when start is high and busy is low; busy rises only when that
// queue is full. Results come out on result with result_valid high for one
// cycle each and cannot be stalled, so the receiver must take every cycle it is
// shown; last marks the final result of a command. A push that reports two set
// events gives two results, any other push or a release one result, and an
// acquire streams its views one per cycle from the registered-read view memory.
// Configuration writes are always ready and should be made only while no
// command is pending.
`default_nettype none

module frameset_assembly_pool #(
    parameter int SLOT_COUNT  = 8,
    parameter int MAX_CAMERAS = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    output logic                busy,
    input  fap_pkg::in_item_t   request,
    output logic                result_valid,
    output fap_pkg::out_item_t  result,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [1:0]          cfg_index,
    input  wire  [63:0]         cfg_data
);
    import fap_pkg::*;

    cfg_t      cfg_reg;
    logic      q_valid;
    in_item_t  q_item;
    logic      q_pop;

    assign cfg_ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.camera_count <= CAMERA_COUNT_RESET;
            cfg_reg.start_time   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_CAMERA_COUNT: cfg_reg.camera_count <= cfg_data[4:0];
                REG_START_TIME:   cfg_reg.start_time   <= cfg_data;
                default:          ;
            endcase
        end
    end

    fap_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .request (request),
        .busy    (busy),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    fap_back #(
        .SLOT_COUNT  (SLOT_COUNT),
        .MAX_CAMERAS (MAX_CAMERAS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

`default_nettype wire

### src/fap_checker.sv
`default_nettype none

module fap_checker (
    input wire                 clk,
    input wire                 rst_n,
    input wire                 result_valid,
    input fap_pkg::out_item_t  result
);
    import fap_pkg::*;

    // Results of one command come back to back
    a_burst: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last |=> result_valid)
        else $error("result burst broken");

    // Only views and a first push result may leave last low
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_VIEW && result.status != ST_ACCEPTED
        |-> result.last)
        else $error("single result without last");

    // A push result that is not last reports a set event
    a_first_push: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.last && result.status == ST_ACCEPTED
        |-> result.set_event != EV_NONE)
        else $error("first push result without set event");

    // Views carry no push side effects
    a_view: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_VIEW
        |-> result.set_event == EV_NONE && !result.oldest_dropped)
        else $error("view with push fields");

endmodule

bind frameset_assembly_pool fap_checker u_fap_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .result       (result)
);

`default_nettype wire

### sim/tb_frameset_assembly_pool.sv
`default_nettype none

module tb_frameset_assembly_pool;
    import fap_pkg::*;

    localparam int SLOTS = 8;
    localparam int MAXCAM = 16;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_item_t request;
    logic result_valid;
    out_item_t result;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [63:0] cfg_data;

    frameset_assembly_pool u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result_valid(result_valid), .result(result), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Pool mirror
    logic [4:0]  cam_cfg;
    logic [63:0] sess_cfg;
    logic [2:0]  free_q [SLOTS];
    int          free_n, free_hd;
    logic [2:0]  done_q [SLOTS];
    int          done_n, done_hd;
    logic        open_v;
    logic [2:0]  open_s;
    logic [63:0] s_time [SLOTS];
    int          s_fill [SLOTS];
    logic [7:0]  v_cam [SLOTS*MAXCAM];
    logic [63:0] v_ptr [SLOTS*MAXCAM];
    logic [15:0] v_pitch [SLOTS*MAXCAM];

    out_item_t pending_results[$];
    int errors;
    int sent;
    int checked;
    int burst_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic int eff_cams();
        if (cam_cfg == 0 || cam_cfg > MAXCAM)
            return MAXCAM;
        return cam_cfg;
    endfunction

    function automatic void pool_put(ref logic [2:0] q[SLOTS], input int hd, ref int n,
                                     input logic [2:0] v);
        if (n >= SLOTS)
            return;
        q[(hd + n) % SLOTS] = v;
        n++;
    endfunction

    function automatic void pool_reset();
        cam_cfg = CAMERA_COUNT_RESET;
        sess_cfg = '0;
        for (int i = 0; i < SLOTS; i++)
        begin
            free_q[i] = i[2:0];
            s_time[i] = '0;
            s_fill[i] = 0;
        end
        free_n = SLOTS;
        free_hd = 0;
        done_n = 0;
        done_hd = 0;
        open_v = 1'b0;
        open_s = '0;
    endfunction

    function automatic logic [1:0] close_set();
        int f;
        f = s_fill[open_s];
        open_v = 1'b0;
        if (f >= MIN_SET_FRAMES)
        begin
            pool_put(done_q, done_hd, done_n, open_s);
            return (f >= eff_cams()) ? EV_FULL : EV_PARTIAL;
        end
        s_time[open_s] = '0;
        s_fill[open_s] = 0;
        pool_put(free_q, free_hd, free_n, open_s);
        return EV_UNDERFILL;
    endfunction

    function automatic out_item_t blank(logic [2:0] st);
        out_item_t r;
        r = '0;
        r.status = st;
        r.last = 1'b1;
        return r;
    endfunction

    // Queue one expected result behind the others
    function automatic void queue_result(out_item_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Predict results of one command
    function automatic void predict_pool(in_item_t it);
        out_item_t r;
        logic [1:0] ev1, ev2;
        logic drop;
        logic [2:0] s;
        int f, n, idx;
        ev1 = EV_NONE;
        ev2 = EV_NONE;
        drop = 1'b0;
        if (it.cmd == CMD_PUSH)
        begin
            if (it.frame_time < sess_cfg)
            begin
                queue_result(blank(ST_PRE_SESSION));
                return;
            end
            if (open_v && it.frame_time > s_time[open_s])
                ev1 = close_set();
            if (!open_v)
            begin
                if (free_n > 0)
                begin
                    s = free_q[free_hd];
                    free_hd = (free_hd + 1) % SLOTS;
                    free_n--;
                end
                else if (done_n > 0)
                begin
                    s = done_q[done_hd];
                    done_hd = (done_hd + 1) % SLOTS;
                    done_n--;
                    s_time[s] = '0;
                    s_fill[s] = 0;
                    drop = 1'b1;
                end
                else
                begin
                    r = blank(ST_NO_SLOT);
                    r.set_event = ev1;
                    queue_result(r);
                    return;
                end
                open_s = s;
                open_v = 1'b1;
                s_time[s] = it.frame_time;
            end
            r = blank(ST_ACCEPTED);
            if (it.frame_time < s_time[open_s])
                r.status = ST_STRAGGLER;
            else
            begin
                f = s_fill[open_s];
                if (f < MAXCAM)
                begin
                    idx = open_s * MAXCAM + f;
                    v_cam[idx] = it.cam_id;
                    v_ptr[idx] = it.frame_ptr;
                    v_pitch[idx] = it.frame_pitch;
                    s_fill[open_s] = f + 1;
                end
                if (s_fill[open_s] >= eff_cams())
                    ev2 = close_set();
            end
            if (ev1 != EV_NONE && ev2 != EV_NONE)
            begin
                out_item_t r0;
                r0 = blank(ST_ACCEPTED);
                r0.set_event = ev1;
                r0.last = 1'b0;
                queue_result(r0);
                ev1 = EV_NONE;
            end
            r.set_event = (ev2 != EV_NONE) ? ev2 : ev1;
            r.oldest_dropped = drop;
            queue_result(r);
        end
        else if (it.cmd == CMD_ACQUIRE)
        begin
            if (done_n == 0)
            begin
                queue_result(blank(ST_ACQ_EMPTY));
                return;
            end
            s = done_q[done_hd];
            done_hd = (done_hd + 1) % SLOTS;
            done_n--;
            n = s_fill[s];
            r = blank(ST_VIEW);
            r.slot_number = s;
            r.set_time = s_time[s];
            if (n == 0)
            begin
                queue_result(r);
                return;
            end
            for (int i = 0; i < n; i++)
            begin
                idx = s * MAXCAM + i;
                r.view_count = n[4:0];
                r.view_camera = v_cam[idx];
                r.view_ptr = v_ptr[idx];
                r.view_pitch = v_pitch[idx];
                r.last = (i == n - 1);
                queue_result(r);
            end
        end
        else if (it.cmd == CMD_RELEASE)
        begin
            s = it.release_slot;
            s_time[s] = '0;
            s_fill[s] = 0;
            pool_put(free_q, free_hd, free_n, s);
            queue_result(blank(ST_RELEASED));
        end
    endfunction

    // Compare every strobed result with the oldest expectation
    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_valid)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t unexpected result: expected none, actual %h", $realtime, result);
            end
            else
            begin
                want = pending_results.pop_front();
                checked++;
                if (result !== want)
                begin
                    errors++;
                    $display("%0t mismatch: expected st=%0d ev=%0d dr=%0d sl=%0d t=%h n=%0d",
                             $realtime, want.status, want.set_event, want.oldest_dropped,
                             want.slot_number, want.set_time, want.view_count);
                    $display("    cam=%h ptr=%h pitch=%h last=%0d", want.view_camera,
                             want.view_ptr, want.view_pitch, want.last);
                    $display("  actual st=%0d ev=%0d dr=%0d sl=%0d t=%h n=%0d",
                             result.status, result.set_event, result.oldest_dropped,
                             result.slot_number, result.set_time, result.view_count);
                    $display("    cam=%h ptr=%h pitch=%h last=%0d", result.view_camera,
                             result.view_ptr, result.view_pitch, result.last);
                end
            end
        end
    end

    // Send one item; gaps may come between random bursts
    task automatic send_item(in_item_t it);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0)
            begin
                start <= 1'b0;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
        burst_left--;
        start <= 1'b1;
        request <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_pool(it);
        sent++;
    endtask

    task automatic drain_pool();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [63:0] val);
        drain_pool();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_CAMERA_COUNT)
            cam_cfg = val[4:0];
        else
            sess_cfg = val;
    endtask

    function automatic in_item_t make_push(logic [7:0] cam, logic [63:0] t);
        in_item_t it;
        it = '0;
        it.cmd = CMD_PUSH;
        it.cam_id = cam;
        it.frame_time = t;
        it.frame_ptr = {$urandom, $urandom};
        it.frame_pitch = 16'($urandom);
        it.release_slot = 3'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_cmd(logic [1:0] c, logic [2:0] sl);
        in_item_t it;
        it = make_push(8'($urandom), {$urandom, $urandom});
        it.cmd = c;
        it.release_slot = sl;
        return it;
    endfunction

    task automatic test_directed();
        in_item_t it;
        send_item(make_cmd(CMD_ACQUIRE, 0));
        send_item(make_push(8'h00, 64'd10));
        send_item(make_push(8'hff, 64'd10));
        send_item(make_push(8'h01, 64'd9));
        it = make_push(8'h02, 64'd10);
        it.frame_ptr = '1;
        it.frame_pitch = '1;
        send_item(it);
        send_item(make_push(8'h03, 64'd10));
        send_item(make_push(8'h04, 64'd20));
        send_item(make_push(8'h05, 64'd30));
        send_item(make_push(8'h06, 64'd30));
        send_item(make_push(8'h07, 64'd40));
        send_item(make_cmd(CMD_ACQUIRE, 0));
        send_item(make_cmd(CMD_ACQUIRE, 0));
        send_item(make_cmd(CMD_ACQUIRE, 0));
        send_item(make_cmd(2'd3, 0));
        send_item(make_cmd(CMD_RELEASE, 3'd7));
        send_item(make_cmd(CMD_RELEASE, 3'd0));
        write_reg(REG_START_TIME, 64'd100);
        send_item(make_push(8'h08, 64'd99));
        send_item(make_push(8'h09, 64'hffff_ffff_ffff_ffff));
        write_reg(REG_CAMERA_COUNT, 5'd1);
        send_item(make_push(8'h0a, 64'hffff_ffff_ffff_ffff));
        write_reg(REG_START_TIME, 64'd0);
    endtask

    // Fill the pool with sets and acquire without releasing, forcing reclaim and no-slot
    task automatic test_exhaust();
        write_reg(REG_CAMERA_COUNT, 5'd2);
        for (int i = 0; i < 20; i++)
        begin
            send_item(make_push(8'($urandom), 64'd1000 + i));
            send_item(make_push(8'($urandom), 64'd1000 + i));
        end
        for (int i = 0; i < 8; i++)
            send_item(make_cmd(CMD_ACQUIRE, 0));
        write_reg(REG_CAMERA_COUNT, 5'd3);
        for (int i = 0; i < 10; i++)
            send_item(make_push(8'($urandom), 64'd2000 + i));
        for (int i = 0; i < 8; i++)
            send_item(make_cmd(CMD_RELEASE, i[2:0]));
    endtask

    // Mostly well-formed frame rounds with noise
    task automatic test_random(int count, logic [4:0] cams);
        logic [63:0] t;
        int k;
        write_reg(REG_CAMERA_COUNT, cams);
        t = 64'd5000 + $urandom_range(0, 100);
        for (int i = 0; i < count; i++)
        begin
            k = $urandom_range(0, 19);
            if (k < 12)
            begin
                if ($urandom_range(0, 4) == 0)
                    t = t + $urandom_range(1, 3);
                send_item(make_push(8'($urandom), t));
            end
            else if (k < 14)
                send_item(make_push(8'($urandom), t - $urandom_range(0, 2)));
            else if (k < 17)
                send_item(make_cmd(CMD_ACQUIRE, 0));
            else if (k < 19)
                send_item(make_cmd(CMD_RELEASE, 3'($urandom)));
            else
                send_item(make_cmd(2'($urandom), 3'($urandom)));
        end
    endtask

    initial
    begin
        #2000000;
        $display("frameset_assembly_pool regression: fail");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        sent = 0;
        checked = 0;
        burst_left = 0;
        pool_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_exhaust();
        test_random(60, 5'd4);
        test_random(80, 5'd16);
        test_random(80, 5'd0);
        test_random(60, 5'd31);
        test_random(60, 5'd3);
        write_reg(REG_START_TIME, 64'hffff_ffff_ffff_ffff);
        send_item(make_push(8'h55, 64'hffff_ffff_ffff_fffe));
        drain_pool();
        $display("covered %0d commands and %0d results: push, acquire, release, reclaim,",
                 sent, checked);
        $display("stragglers, session cutoff and camera counts 0 to 31");
        if (errors == 0)
            $display("frameset_assembly_pool regression: pass");
        else
            $display("frameset_assembly_pool regression: fail");
        $finish;
    end
endmodule

`default_nettype wire

### sim.f
src/fap_pkg.sv
src/fap_front.sv
src/fap_back.sv
src/frameset_assembly_pool.sv
src/fap_checker.sv
sim/tb_frameset_assembly_pool.sv
